@@ hw/rtl/cubic_bezier_flattener_defines.svh @@
// Assertion macros shared by the flattener RTL.
// CBF_ASSERT is held off while reset is asserted.
// CBF_ASSERT_ALWAYS is checked at every rising clock edge, reset included.
`ifndef CUBIC_BEZIER_FLATTENER_DEFINES_SVH
`define CUBIC_BEZIER_FLATTENER_DEFINES_SVH
`ifndef SYNTHESIS
`define CBF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`define CBF_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) \
    else $error(msg);
`else
`define CBF_ASSERT(label, prop, msg)
`define CBF_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

@@ hw/rtl/cbf_pkg.sv @@
package cbf_pkg;

  // Field widths.
  localparam int unsigned CoordW  = 16;
  localparam int unsigned ColourW = 24;
  localparam int unsigned ScaleW  = 16;
  localparam int unsigned OutW    = 32;
  localparam int unsigned WeightW = 17;
  localparam int unsigned ProdW   = 33;

  // Register map.
  localparam logic RegXyScale = 1'b0;
  localparam logic [ScaleW-1:0] XyScaleReset = 16'd256;

  // One curve: coordinates in the order start, ctrl_a, ctrl_b, finish,
  // x before y, so coordinate 2*j+axis belongs to Bernstein term j.
  typedef struct packed {
    logic [7:0][CoordW-1:0] coord;
    logic [ColourW-1:0]     colour;
  } curve_t;

  // One step after the product stage.
  typedef struct packed {
    logic                        valid;
    logic                        first;
    logic                        last;
    logic [ColourW-1:0]          colour;
    logic [CoordW-1:0]           start_x;
    logic [CoordW-1:0]           start_y;
    logic [1:0][3:0][ProdW-1:0]  prod;
  } prod_t;

  // One finished segment.
  typedef struct packed {
    logic [OutW-1:0]    x0;
    logic [OutW-1:0]    y0;
    logic [OutW-1:0]    x1;
    logic [OutW-1:0]    y1;
    logic [ColourW-1:0] colour;
    logic               last;
  } seg_t;

endpackage

@@ hw/rtl/cbf_fifo.sv @@
`include "cubic_bezier_flattener_defines.svh"

module cbf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             do_push, do_pop;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] ptr);
    return (ptr == PtrW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
  endfunction

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  `CBF_ASSERT(a_count_bound, count_q <= CntW'(DEPTH), "fifo count exceeds depth")

endmodule

@@ hw/rtl/cbf_sequencer.sv @@
`include "cubic_bezier_flattener_defines.svh"

module cbf_sequencer #(
  parameter int unsigned SEGMENTS = 25
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  cbf_pkg::curve_t in_curve_i,
  output logic           in_pop_o,
  input  logic           adv_i,
  output cbf_pkg::prod_t prod_o
);

  import cbf_pkg::*;

  localparam int unsigned KW = $clog2(SEGMENTS + 1);
  localparam logic [KW-1:0] LastK = KW'(SEGMENTS);
  localparam longint unsigned Den = longint'(SEGMENTS) * SEGMENTS * SEGMENTS;

  logic [WeightW-1:0] wt [4][SEGMENTS+1];
  logic               active_q;
  logic [KW-1:0]      k_q;
  curve_t             cur_q;
  logic               load, issue;
  logic [1:0][3:0][ProdW-1:0] prod_d;
  prod_t              prod_q;

  // Rounded Q1.16 Bernstein weights for every step, fixed at elaboration.
  for (genvar k = 0; k <= SEGMENTS; k++) begin : g_wt
    localparam longint unsigned Kl = k;
    localparam longint unsigned Ul = SEGMENTS - k;
    localparam longint unsigned W0 = (Ul * Ul * Ul * 65536 + Den / 2) / Den;
    localparam longint unsigned W1 = (3 * Ul * Ul * Kl * 65536 + Den / 2) / Den;
    localparam longint unsigned W2 = (3 * Ul * Kl * Kl * 65536 + Den / 2) / Den;
    localparam longint unsigned W3 = (Kl * Kl * Kl * 65536 + Den / 2) / Den;
    assign wt[0][k] = WeightW'(W0);
    assign wt[1][k] = WeightW'(W1);
    assign wt[2][k] = WeightW'(W2);
    assign wt[3][k] = WeightW'(W3);
  end

  // A new curve loads when idle or while its predecessor issues its last step.
  assign issue    = active_q && adv_i;
  assign load     = in_valid_i && (!active_q || (issue && k_q == LastK));
  assign in_pop_o = load;

  // Step counter runs 1..SEGMENTS for each curve.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      k_q      <= '0;
    end else if (load) begin
      active_q <= 1'b1;
      k_q      <= KW'(1);
    end else if (issue) begin
      if (k_q == LastK) begin
        active_q <= 1'b0;
        k_q      <= '0;
      end else begin
        k_q <= k_q + 1'b1;
      end
    end
  end

  // Held curve points.
  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= in_curve_i;
    end
  end

  // Eight weight-by-coordinate products, one per term and axis.
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      for (int j = 0; j < 4; j++) begin
        prod_d[a][j] = ProdW'($signed({1'b0, wt[j][k_q]}))
                     * ProdW'($signed(cur_q.coord[2*j+a]));
      end
    end
  end

  // Product stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
    end else begin
      if (adv_i) begin
        prod_q.valid <= issue;
      end
      if (issue) begin
        prod_q.first   <= (k_q == KW'(1));
        prod_q.last    <= (k_q == LastK);
        prod_q.colour  <= cur_q.colour;
        prod_q.start_x <= cur_q.coord[0];
        prod_q.start_y <= cur_q.coord[1];
        prod_q.prod    <= prod_d;
      end
    end
  end

  assign prod_o = prod_q;

  `CBF_ASSERT(a_step_range, active_q |-> (k_q != '0) && (k_q <= LastK), "step out of range")
  `CBF_ASSERT(a_chain_restart, (load && active_q) |=> active_q && (k_q == KW'(1)), "no restart")

endmodule

@@ hw/rtl/cbf_datapath.sv @@
module cbf_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  cbf_pkg::prod_t              prod_i,
  input  logic [cbf_pkg::ScaleW-1:0]  xy_scale_i,
  output logic                        seg_valid_o,
  output cbf_pkg::seg_t               seg_o
);

  import cbf_pkg::*;

  logic signed [34:0]       sum [2];
  logic signed [34:0]       shifted [2];
  logic signed [CoordW-1:0] pt [2];
  logic                     b_valid_q;
  logic                     b_last_q;
  logic [ColourW-1:0]       b_colour_q;
  logic signed [CoordW-1:0] b_prev_x_q, b_prev_y_q, b_cur_x_q, b_cur_y_q;
  logic signed [ScaleW:0]   scale_s;
  logic signed [OutW-1:0]   m_x0, m_y0, m_x1, m_y1;

  function automatic logic signed [CoordW-1:0] sat16(input logic signed [34:0] v);
    if (v > 35'sd32767) begin
      return 16'sh7fff;
    end else if (v < -35'sd32768) begin
      return 16'sh8000;
    end else begin
      return v[CoordW-1:0];
    end
  endfunction

  // Blend the four terms, floor to Q8.8 and clamp to 16 bits.
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      sum[a] = 35'($signed(prod_i.prod[a][0])) + 35'($signed(prod_i.prod[a][1]))
             + 35'($signed(prod_i.prod[a][2])) + 35'($signed(prod_i.prod[a][3]));
      shifted[a] = sum[a] >>> 16;
      pt[a] = sat16(shifted[a]);
    end
  end

  // Point stage: the previous point is the curve start on the first step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (adv_i) begin
      b_valid_q <= prod_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && prod_i.valid) begin
      b_prev_x_q <= prod_i.first ? $signed(prod_i.start_x) : b_cur_x_q;
      b_prev_y_q <= prod_i.first ? $signed(prod_i.start_y) : b_cur_y_q;
      b_cur_x_q  <= pt[0];
      b_cur_y_q  <= pt[1];
      b_colour_q <= prod_i.colour;
      b_last_q   <= prod_i.last;
    end
  end

  // Scale both ends. A 16-bit signed point times a 16-bit unsigned scale
  // always fits 32 signed bits, so no 32-bit clamp is needed.
  assign scale_s = $signed({1'b0, xy_scale_i});
  assign m_x0 = OutW'(b_prev_x_q) * OutW'(scale_s);
  assign m_y0 = OutW'(b_prev_y_q) * OutW'(scale_s);
  assign m_x1 = OutW'(b_cur_x_q) * OutW'(scale_s);
  assign m_y1 = OutW'(b_cur_y_q) * OutW'(scale_s);

  assign seg_valid_o   = b_valid_q;
  assign seg_o.x0      = m_x0 >>> 8;
  assign seg_o.y0      = m_y0 >>> 8;
  assign seg_o.x1      = m_x1 >>> 8;
  assign seg_o.y1      = m_y1 >>> 8;
  assign seg_o.colour  = b_colour_q;
  assign seg_o.last    = b_last_q;

endmodule

@@ hw/rtl/cubic_bezier_flattener.sv @@
// Channel   Direction  Handshake               Payload
// curve     in         push / full             four Q8.8 points, colour
// segment   out        empty / pop             two scaled Q8.8 ends, colour, last
// config    in         APB psel/penable/pready xy_scale at byte address 0
//
// Each curve yields SEGMENTS segments, one per cycle while the output queue has
// room: the sequencer issues one Bernstein step a cycle and loads the next curve
// with the last step. Steps pass the product, point and segment-queue registers.
// Reset empties both queues, idles the sequencer and sets xy_scale to 1.0.
// When the output queue is full the pipeline holds; the input queue keeps
// up to two curves so the front side stalls only when both are waiting.
module cubic_bezier_flattener #(
  parameter int unsigned SEGMENTS = 25
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Curve input.
  input  logic                            push,
  output logic                            full,
  input  logic signed [cbf_pkg::CoordW-1:0] start_x_i,
  input  logic signed [cbf_pkg::CoordW-1:0] start_y_i,
  input  logic signed [cbf_pkg::CoordW-1:0] ctrl_a_x_i,
  input  logic signed [cbf_pkg::CoordW-1:0] ctrl_a_y_i,
  input  logic signed [cbf_pkg::CoordW-1:0] ctrl_b_x_i,
  input  logic signed [cbf_pkg::CoordW-1:0] ctrl_b_y_i,
  input  logic signed [cbf_pkg::CoordW-1:0] finish_x_i,
  input  logic signed [cbf_pkg::CoordW-1:0] finish_y_i,
  input  logic [cbf_pkg::ColourW-1:0]     line_colour_i,
  // Segment output.
  output logic                            empty,
  input  logic                            pop,
  output logic signed [cbf_pkg::OutW-1:0] seg_x0_o,
  output logic signed [cbf_pkg::OutW-1:0] seg_y0_o,
  output logic signed [cbf_pkg::OutW-1:0] seg_x1_o,
  output logic signed [cbf_pkg::OutW-1:0] seg_y1_o,
  output logic [cbf_pkg::ColourW-1:0]     seg_colour_o,
  output logic                            seg_last_o,
  // Configuration.
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  import cbf_pkg::*;

  localparam int unsigned CurveW = $bits(curve_t);
  localparam int unsigned SegW   = $bits(seg_t);

  curve_t            in_curve, q_curve;
  logic [CurveW-1:0] q_rdata;
  logic              q_empty, q_pop;
  prod_t             prod;
  seg_t              seg, out_seg;
  logic [SegW-1:0]   out_rdata;
  logic              seg_valid, out_full, adv;
  logic [ScaleW-1:0] xy_scale_q;

  // Configuration register.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xy_scale_q <= XyScaleReset;
    end else if (psel && penable && pwrite && pready && paddr[2] == RegXyScale) begin
      xy_scale_q <= pwdata[ScaleW-1:0];
    end
  end

  assign prdata = (paddr[2] == RegXyScale) ? {16'b0, xy_scale_q} : '0;

  // Front: curve queue.
  assign in_curve.coord[0] = start_x_i;
  assign in_curve.coord[1] = start_y_i;
  assign in_curve.coord[2] = ctrl_a_x_i;
  assign in_curve.coord[3] = ctrl_a_y_i;
  assign in_curve.coord[4] = ctrl_b_x_i;
  assign in_curve.coord[5] = ctrl_b_y_i;
  assign in_curve.coord[6] = finish_x_i;
  assign in_curve.coord[7] = finish_y_i;
  assign in_curve.colour   = line_colour_i;

  cbf_fifo #(
    .WIDTH(CurveW),
    .DEPTH(2)
  ) u_in_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(in_curve),
    .full_o (full),
    .pop_i  (q_pop),
    .rdata_o(q_rdata),
    .empty_o(q_empty)
  );

  assign q_curve = curve_t'(q_rdata);

  // Back: the pipeline moves whenever the output queue has room.
  assign adv = !out_full;

  cbf_sequencer #(
    .SEGMENTS(SEGMENTS)
  ) u_sequencer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(!q_empty),
    .in_curve_i(q_curve),
    .in_pop_o  (q_pop),
    .adv_i     (adv),
    .prod_o    (prod)
  );

  cbf_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .prod_i     (prod),
    .xy_scale_i (xy_scale_q),
    .seg_valid_o(seg_valid),
    .seg_o      (seg)
  );

  // Segment queue.
  cbf_fifo #(
    .WIDTH(SegW),
    .DEPTH(2)
  ) u_out_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (seg_valid),
    .wdata_i(seg),
    .full_o (out_full),
    .pop_i  (pop),
    .rdata_o(out_rdata),
    .empty_o(empty)
  );

  assign out_seg      = seg_t'(out_rdata);
  assign seg_x0_o     = out_seg.x0;
  assign seg_y0_o     = out_seg.y0;
  assign seg_x1_o     = out_seg.x1;
  assign seg_y1_o     = out_seg.y1;
  assign seg_colour_o = out_seg.colour;
  assign seg_last_o   = out_seg.last;

endmodule

@@ bench/tb_cubic_bezier_flattener.sv @@
`timescale 1ns / 1ps

module tb_cubic_bezier_flattener;
  import cbf_pkg::*;

  localparam int unsigned NumSteps = 25;
  localparam int unsigned RandomCurves = 210;
  localparam int unsigned CycleLimit = 400000;
  localparam logic [2:0] AddrXyScale = 3'(4 * RegXyScale);
  // Byte address of the first register slot past the map.
  localparam logic [2:0] AddrUnmapped = 3'd4;

  // Predicts the segments of each curve and checks them in order.
  class segment_scoreboard;
    logic [ScaleW-1:0] scale;
    seg_t expected_segs[$];
    int unsigned failures;

    function new();
      scale = XyScaleReset;
      failures = 0;
    endfunction

    // Only the scale register exists; writes elsewhere are dropped.
    function void write_reg(logic [2:0] addr, logic [31:0] data);
      if ((addr >> 2) == RegXyScale) begin
        scale = data[ScaleW-1:0];
      end
    endfunction

    // Rounded Q1.16 Bernstein weight of term j at step k.
    function longint bern_weight(int j, int k);
      longint u, kk, n, d;
      u = NumSteps - k;
      kk = k;
      d = NumSteps * NumSteps * NumSteps;
      case (j)
        0: n = u * u * u;
        1: n = 3 * u * u * kk;
        2: n = 3 * u * kk * kk;
        default: n = kk * kk * kk;
      endcase
      return (n * 65536 + d / 2) / d;
    endfunction

    // Curve coordinate at step k, floored to Q8.8 and saturated to 16 bits.
    function logic signed [CoordW-1:0] curve_point(curve_t c, int k, int axis);
      longint acc, v;
      acc = 0;
      for (int j = 0; j < 4; j++) begin
        acc += bern_weight(j, k) * longint'($signed(c.coord[2 * j + axis]));
      end
      v = acc >>> 16;
      if (v > 32767) v = 32767;
      else if (v < -32768) v = -32768;
      return v[CoordW-1:0];
    endfunction

    // Scaled output coordinate, floored to Q8.8 and saturated to 32 bits.
    function logic [OutW-1:0] scale_coord(logic signed [CoordW-1:0] p);
      longint v;
      v = (longint'(p) * longint'(scale)) >>> 8;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      else if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[OutW-1:0];
    endfunction

    function void note_curve(curve_t c);
      logic signed [CoordW-1:0] px, py, nx, ny;
      seg_t s;
      px = curve_point(c, 0, 0);
      py = curve_point(c, 0, 1);
      for (int k = 1; k <= NumSteps; k++) begin
        nx = curve_point(c, k, 0);
        ny = curve_point(c, k, 1);
        s.x0 = scale_coord(px);
        s.y0 = scale_coord(py);
        s.x1 = scale_coord(nx);
        s.y1 = scale_coord(ny);
        s.colour = c.colour;
        s.last = (k == NumSteps);
        expected_segs.push_back(s);
        px = nx;
        py = ny;
      end
    endfunction

    function int pending();
      return expected_segs.size();
    endfunction

    task report(string what, logic [OutW-1:0] got, logic [OutW-1:0] want);
      failures++;
      $display("ERROR %s: got %h, expected %h", what, got, want);
    endtask

    task check_segment(seg_t got);
      seg_t want;
      if (expected_segs.size() == 0) begin
        report("segment with no curve pending", got.x0, '0);
        return;
      end
      want = expected_segs.pop_front();
      if (got.x0 !== want.x0) report("seg_x0", got.x0, want.x0);
      if (got.y0 !== want.y0) report("seg_y0", got.y0, want.y0);
      if (got.x1 !== want.x1) report("seg_x1", got.x1, want.x1);
      if (got.y1 !== want.y1) report("seg_y1", got.y1, want.y1);
      if (got.colour !== want.colour) begin
        report("seg_colour", OutW'(got.colour), OutW'(want.colour));
      end
      if (got.last !== want.last) report("seg_last", OutW'(got.last), OutW'(want.last));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic signed [CoordW-1:0] start_x_i = '0, start_y_i = '0;
  logic signed [CoordW-1:0] ctrl_a_x_i = '0, ctrl_a_y_i = '0;
  logic signed [CoordW-1:0] ctrl_b_x_i = '0, ctrl_b_y_i = '0;
  logic signed [CoordW-1:0] finish_x_i = '0, finish_y_i = '0;
  logic [ColourW-1:0] line_colour_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [OutW-1:0] seg_x0_o, seg_y0_o, seg_x1_o, seg_y1_o;
  logic [ColourW-1:0] seg_colour_o;
  logic seg_last_o;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  segment_scoreboard sb = new();
  int unsigned send_idle = 21;
  int unsigned recv_idle = 62;
  int unsigned cycles = 0;
  curve_t seen_curve;
  seg_t seen_seg;

  cubic_bezier_flattener #(.SEGMENTS(NumSteps)) dut (
    .clk_i, .rst_ni,
    .push, .full,
    .start_x_i, .start_y_i, .ctrl_a_x_i, .ctrl_a_y_i,
    .ctrl_b_x_i, .ctrl_b_y_i, .finish_x_i, .finish_y_i,
    .line_colour_i,
    .empty, .pop,
    .seg_x0_o, .seg_y0_o, .seg_x1_o, .seg_y1_o, .seg_colour_o, .seg_last_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // The receiver stalls at random.
  always @(posedge clk_i) begin
    pop <= rst_ni && ($urandom_range(99) >= recv_idle);
  end

  // Observe accepted curves, segments and register writes.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push && !full) begin
        seen_curve.coord[0] = start_x_i;
        seen_curve.coord[1] = start_y_i;
        seen_curve.coord[2] = ctrl_a_x_i;
        seen_curve.coord[3] = ctrl_a_y_i;
        seen_curve.coord[4] = ctrl_b_x_i;
        seen_curve.coord[5] = ctrl_b_y_i;
        seen_curve.coord[6] = finish_x_i;
        seen_curve.coord[7] = finish_y_i;
        seen_curve.colour = line_colour_i;
        sb.note_curve(seen_curve);
      end
      if (pop && !empty) begin
        seen_seg.x0 = seg_x0_o;
        seen_seg.y0 = seg_y0_o;
        seen_seg.x1 = seg_x1_o;
        seen_seg.y1 = seg_y1_o;
        seen_seg.colour = seg_colour_o;
        seen_seg.last = seg_last_o;
        sb.check_segment(seen_seg);
      end
      if (psel && penable && pwrite && pready) begin
        sb.write_reg(paddr, pwdata);
      end
    end
  end

  function automatic curve_t make_curve(int sx, int sy, int ax, int ay,
                                        int bx, int by, int fx, int fy,
                                        logic [ColourW-1:0] col);
    curve_t c;
    c.coord[0] = CoordW'(sx);
    c.coord[1] = CoordW'(sy);
    c.coord[2] = CoordW'(ax);
    c.coord[3] = CoordW'(ay);
    c.coord[4] = CoordW'(bx);
    c.coord[5] = CoordW'(by);
    c.coord[6] = CoordW'(fx);
    c.coord[7] = CoordW'(fy);
    c.colour = col;
    return c;
  endfunction

  // Mostly uniform coordinates, with the range edges mixed in.
  function automatic curve_t random_curve();
    curve_t c;
    for (int i = 0; i < 8; i++) begin
      case ($urandom_range(15))
        0: c.coord[i] = 16'h8000;
        1: c.coord[i] = 16'h7fff;
        2: c.coord[i] = 16'h0000;
        3: c.coord[i] = 16'hffff;
        default: c.coord[i] = CoordW'($urandom());
      endcase
    end
    c.colour = ColourW'($urandom());
    return c;
  endfunction

  // Offer one curve after a random gap and hold it until it is taken.
  task automatic send_curve(curve_t c);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    start_x_i <= c.coord[0];
    start_y_i <= c.coord[1];
    ctrl_a_x_i <= c.coord[2];
    ctrl_a_y_i <= c.coord[3];
    ctrl_b_x_i <= c.coord[4];
    ctrl_b_y_i <= c.coord[5];
    finish_x_i <= c.coord[6];
    finish_y_i <= c.coord[7];
    line_colour_i <= c.colour;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // Stop sending and wait until every expected segment has come out.
  task automatic drain_pause();
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed curves at the reset scale: flat, extreme and zigzag shapes.
    send_curve(make_curve(0, 0, 0, 0, 0, 0, 0, 0, 24'h000000));
    send_curve(make_curve(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                          24'hffffff));
    // Weights that sum above one push this curve past the low saturation point.
    send_curve(make_curve(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                          24'h000000));
    send_curve(make_curve(-32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768,
                          24'haaaaaa));
    send_curve(make_curve(32767, -32768, -32768, 32767, 32767, -32768, -32768, 32767,
                          24'h555555));
    send_curve(make_curve(0, 0, 256, 256, 512, 512, 768, 768, 24'h123456));
    send_curve(make_curve(-1, 1, 1, -1, -1, 1, 1, -1, 24'h800001));

    // Largest scale.
    drain_pause();
    write_reg(AddrXyScale, 32'h0000_ffff);
    send_curve(make_curve(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                          24'h0f0f0f));
    send_curve(make_curve(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768,
                          24'hf0f0f0));
    send_curve(make_curve(-32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768,
                          24'h00ff00));

    // Zero scale flattens every segment to the origin.
    drain_pause();
    write_reg(AddrXyScale, 32'h0000_0000);
    send_curve(random_curve());

    // A write past the register map must leave the scale alone.
    drain_pause();
    write_reg(AddrUnmapped, 32'h5a5a_0100);
    send_curve(random_curve());

    // Smallest nonzero scale; the upper data bits are not part of the register.
    drain_pause();
    write_reg(AddrXyScale, 32'hffff_0001);
    send_curve(random_curve());

    // Random curves in three idling patterns, each at its own scale.
    for (int phase = 0; phase < 3; phase++) begin
      drain_pause();
      case (phase)
        0: write_reg(AddrXyScale, $urandom_range(65535));
        1: write_reg(AddrXyScale, $urandom_range(1, 1023));
        default: write_reg(AddrXyScale, 32'(XyScaleReset));
      endcase
      case (phase)
        0: begin
          send_idle = 21;
          recv_idle = 62;
        end
        1: begin
          send_idle = 62;
          recv_idle = 21;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      repeat (RandomCurves / 3) send_curve(random_curve());
    end

    drain_pause();
    if (sb.failures == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
